// ===== hdl/rsac_pkg.sv =====
// shared types and constants of the rtd slew average converter
`timescale 1ns / 1ps
`default_nettype none

package rsac_pkg;

	// field widths
	localparam int SAMPLE_W = 12;
	localparam int ADC_BITS = 12;
	localparam int TRK_W    = 20;
	localparam int ACC_W    = 28;
	localparam int CFG_W    = 24;
	localparam int IDX_W    = 3;
	localparam int VOLT_W   = 19;
	localparam int OHM_W    = 24;
	localparam int GAIN_W   = 24;
	localparam int TEMP_W   = 20;
	localparam int FAULT_W  = 2;

	// adc mask, all ones when the converter is as wide as the port
	localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);

	// serial arithmetic unit sizes
	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;
	localparam int DIV_N_W = 43;
	localparam int DIV_D_W = 24;

	// 4180 counts full scale, times 256 for the q12.8 average
	localparam logic [DIV_D_W-1:0] REF_DEN = 24'd1070080;

	// register indexes
	localparam logic [IDX_W-1:0] REG_WINDOW       = 3'd0;
	localparam logic [IDX_W-1:0] REG_STEP_SIZE    = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_SLOPE   = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_OFFSET  = 3'd3;
	localparam logic [IDX_W-1:0] REG_DIVIDER_OHMS = 3'd4;
	localparam logic [IDX_W-1:0] REG_SUPPLY_VOLTS = 3'd5;
	localparam logic [IDX_W-1:0] REG_TEMP_SLOPE   = 3'd6;
	localparam logic [IDX_W-1:0] REG_TEMP_OFFSET  = 3'd7;

	// fault codes
	localparam logic [FAULT_W-1:0] FAULT_OK     = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_GAIN   = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_BRIDGE = 2'd2;

	// end of a run, handed from the tracker to the converter
	typedef struct packed {
		logic             valid;
		logic [ACC_W-1:0] sum;
	} rsac_run_t;

endpackage

`default_nettype wire

// ===== hdl/rsac_tracker.sv =====
// slew tracker, accumulator and run counter
`timescale 1ns / 1ps
`default_nettype none

module rsac_tracker #(
	parameter int MAX_SAMPLES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [rsac_pkg::SAMPLE_W-1:0]  sample,
	input  logic [11:0]                    window,
	input  logic [11:0]                    step_size,
	output rsac_pkg::rsac_run_t            run
);
	import rsac_pkg::*;

	localparam int CNT_W = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_SAMPLES - 1);

	logic [TRK_W-1:0]  tracker_q;
	logic [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  count_q;
	logic              seeded_q;
	rsac_run_t         run_q;

	logic [SAMPLE_W-1:0]    s;
	logic [TRK_W-1:0]       s8;
	logic signed [TRK_W+1:0] s_x, lo_x, hi_x;
	logic [TRK_W:0]         t_up, t_dn;
	logic                   in_band;
	logic [TRK_W-1:0]       used;
	logic [ACC_W-1:0]       acc_next;

	always_comb begin
		s    = sample & ADC_MASK;
		s8   = {s, 8'd0};
		s_x  = {2'b00, s8};
		lo_x = $signed({2'b00, tracker_q}) - $signed({2'b00, window, 8'd0});
		hi_x = $signed({2'b00, tracker_q}) + $signed({2'b00, window, 8'd0});
		in_band = (s_x > lo_x) && (s_x < hi_x);
		t_up = {1'b0, tracker_q} + {9'd0, step_size};
		t_dn = {1'b0, tracker_q} - {9'd0, step_size};
		if (!seeded_q || in_band) begin
			used = s8;
		end else if (s8 > tracker_q) begin
			used = t_up[TRK_W] ? {TRK_W{1'b1}} : t_up[TRK_W-1:0];
		end else begin
			used = t_dn[TRK_W] ? {TRK_W{1'b0}} : t_dn[TRK_W-1:0];
		end
		acc_next = acc_q + {{(ACC_W-TRK_W){1'b0}}, used};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracker_q <= '0;
			acc_q     <= '0;
			count_q   <= '0;
			seeded_q  <= 1'b0;
			run_q     <= '0;
		end else begin
			run_q.valid <= 1'b0;
			if (accept) begin
				tracker_q <= used;
				seeded_q  <= 1'b1;
				if (count_q == CNT_LAST) begin
					count_q     <= '0;
					acc_q       <= '0;
					run_q.valid <= 1'b1;
					run_q.sum   <= acc_next;
				end else begin
					count_q <= count_q + 1'b1;
					acc_q   <= acc_next;
				end
			end
		end
	end

	assign run = run_q;

endmodule

`default_nettype wire

// ===== hdl/rsac_serial_mul.sv =====
// bit-serial signed by unsigned shift-add multiplier
`timescale 1ns / 1ps
`default_nettype none

module rsac_serial_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rsac_pkg::MUL_A_W-1:0]  a,
	input  logic [rsac_pkg::MUL_B_W-1:0]  b,
	output logic                          done,
	output logic [rsac_pkg::MUL_P_W-1:0]  p
);
	import rsac_pkg::*;

	localparam int CNT_W = $clog2(MUL_B_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_B_W - 1);

	logic [MUL_A_W-1:0] a_q;
	logic [MUL_A_W:0]   hi_q;
	logic [MUL_B_W-1:0] lo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [MUL_A_W:0]   sum;

	// add the sign-extended multiplicand when the low bit is set
	always_comb begin
		sum = hi_q + (lo_q[0] ? {a_q[MUL_A_W-1], a_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= {sum[MUL_A_W], sum[MUL_A_W:1]};
			lo_q <= {sum[0], lo_q[MUL_B_W-1:1]};
		end
	end

	assign done = done_q;
	assign p    = {hi_q, lo_q};

endmodule

`default_nettype wire

// ===== hdl/rsac_serial_div.sv =====
// bit-serial restoring unsigned divider
`timescale 1ns / 1ps
`default_nettype none

module rsac_serial_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rsac_pkg::DIV_N_W-1:0]  n,
	input  logic [rsac_pkg::DIV_D_W-1:0]  d,
	output logic                          done,
	output logic [rsac_pkg::DIV_N_W-1:0]  q
);
	import rsac_pkg::*;

	localparam int CNT_W = $clog2(DIV_N_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_N_W - 1);

	logic [DIV_D_W-1:0] d_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_N_W-1:0] nq_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DIV_D_W:0]   trial;
	logic [DIV_D_W:0]   diff;
	logic               fits;

	always_comb begin
		trial = {rem_q, nq_q[DIV_N_W-1]};
		diff  = trial - {1'b0, d_q};
		fits  = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator bits shift out at the top, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= d;
			rem_q <= '0;
			nq_q  <= n;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			nq_q  <= {nq_q[DIV_N_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign q    = nq_q;

endmodule

`default_nettype wire

// ===== hdl/rtd_slew_average_converter_core.sv =====
// top level of the rtd slew average converter
// Conditions 12-bit resistance-sensor ADC samples and converts the average of each run of
// MAX_SAMPLES samples into volts, gain, bridge voltage, resistance and temperature. A tracker
// follows the samples: a sample strictly inside +/- window counts of it is used and becomes
// the tracker, an outlier only moves the tracker by step_size toward it and the tracker is
// used; the very first word after reset seeds the tracker. The last word of a run starts the
// conversion, which runs on one bit-serial multiplier (24 steps) and one restoring divider
// (43 steps), up to four passes of each; no sample word is taken until the result is handed
// to the output register. The output register holds one result word while the next run
// collects samples. Fault 1 means the modelled gain is not positive, fault 2 that the bridge
// voltage reaches the supply. Configuration is written through cfg_wr_en/cfg_index/cfg_data;
// the user must write it only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module rtd_slew_average_converter_core #(
	parameter int MAX_SAMPLES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_wr_en,
	input  logic [rsac_pkg::IDX_W-1:0]           cfg_index,
	input  logic [rsac_pkg::CFG_W-1:0]           cfg_data,
	// sample words
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [rsac_pkg::SAMPLE_W-1:0]        sample,
	// result words
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [rsac_pkg::TRK_W-1:0]           average,
	output logic [rsac_pkg::VOLT_W-1:0]          measured_volts,
	output logic [rsac_pkg::GAIN_W-1:0]          gain,
	output logic [rsac_pkg::VOLT_W-1:0]          bridge_volts,
	output logic [rsac_pkg::OHM_W-1:0]           resistance,
	output logic signed [rsac_pkg::TEMP_W-1:0]   temperature,
	output logic [rsac_pkg::FAULT_W-1:0]         fault
);
	import rsac_pkg::*;

	// conversion sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_AVG_DV = 4'd1;
	localparam logic [3:0] ST_MV_MUL = 4'd2;
	localparam logic [3:0] ST_MV_DIV = 4'd3;
	localparam logic [3:0] ST_G_MUL  = 4'd4;
	localparam logic [3:0] ST_BR_DIV = 4'd5;
	localparam logic [3:0] ST_R_MUL  = 4'd6;
	localparam logic [3:0] ST_R_DIV  = 4'd7;
	localparam logic [3:0] ST_T_MUL  = 4'd8;
	localparam logic [3:0] ST_HOLD   = 4'd9;

	localparam int SHR_W = MUL_P_W - 16;
	localparam int SUM_W = SHR_W + 2;

	// configuration registers
	logic [11:0]        window_q;
	logic [11:0]        step_size_q;
	logic [GAIN_W-1:0]  gain_slope_q;
	logic [GAIN_W-1:0]  gain_offset_q;
	logic [OHM_W-1:0]   divider_ohms_q;
	logic [VOLT_W-1:0]  supply_volts_q;
	logic [TEMP_W-1:0]  temp_slope_q;
	logic [TEMP_W-1:0]  temp_offset_q;

	// sequencer and intermediate results
	logic [3:0]         state_q;
	logic               go_q;
	logic [TRK_W-1:0]   avg_q;
	logic [VOLT_W-1:0]  mv_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [VOLT_W-1:0]  bridge_q;
	logic [OHM_W-1:0]   res_q;
	logic [TEMP_W-1:0]  temp_q;
	logic [FAULT_W-1:0] fault_q;

	// output register
	logic               out_valid_q;
	logic [TRK_W-1:0]   out_avg_q;
	logic [VOLT_W-1:0]  out_mv_q;
	logic [GAIN_W-1:0]  out_gain_q;
	logic [VOLT_W-1:0]  out_bridge_q;
	logic [OHM_W-1:0]   out_res_q;
	logic [TEMP_W-1:0]  out_temp_q;
	logic [FAULT_W-1:0] out_fault_q;

	rsac_run_t          run;
	logic               in_accept;

	logic               mul_start, mul_done;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;
	logic               div_start, div_done;
	logic [DIV_N_W-1:0] div_n;
	logic [DIV_D_W-1:0] div_d;
	logic [DIV_N_W-1:0] div_q;

	logic [SHR_W-1:0]   shr;
	logic [SUM_W-1:0]   g_sum, t_sum;
	logic               g_pos;
	logic [GAIN_W-1:0]  g_sat;
	logic [VOLT_W-1:0]  q_sat19;
	logic [OHM_W-1:0]   q_sat24;
	logic [TEMP_W-1:0]  t_sat;
	logic               out_load;

	// samples only while no conversion is pending
	assign in_ready  = (state_q == ST_IDLE) && !run.valid;
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q       <= 12'd16;
			step_size_q    <= 12'd26;
			gain_slope_q   <= 24'd0;
			gain_offset_q  <= 24'd65536;
			divider_ohms_q <= 24'd256000;
			supply_volts_q <= 19'd216269;
			temp_slope_q   <= 20'd170394;
			temp_offset_q  <= 20'hEFC4D; // -66483 in q12.8
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WINDOW:       window_q       <= cfg_data[11:0];
				REG_STEP_SIZE:    step_size_q    <= cfg_data[11:0];
				REG_GAIN_SLOPE:   gain_slope_q   <= cfg_data[GAIN_W-1:0];
				REG_GAIN_OFFSET:  gain_offset_q  <= cfg_data[GAIN_W-1:0];
				REG_DIVIDER_OHMS: divider_ohms_q <= cfg_data[OHM_W-1:0];
				REG_SUPPLY_VOLTS: supply_volts_q <= cfg_data[VOLT_W-1:0];
				REG_TEMP_SLOPE:   temp_slope_q   <= cfg_data[TEMP_W-1:0];
				REG_TEMP_OFFSET:  temp_offset_q  <= cfg_data[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	rsac_tracker #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.sample    (sample),
		.window    (window_q),
		.step_size (step_size_q),
		.run       (run)
	);

	// operand selection per sequencer step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_n = '0;
		div_d = REF_DEN;
		case (state_q)
			ST_MV_MUL: begin
				mul_a = {6'd0, supply_volts_q};
				mul_b = {4'd0, avg_q};
			end
			ST_G_MUL: begin
				mul_a = {gain_slope_q[GAIN_W-1], gain_slope_q};
				mul_b = {5'd0, mv_q};
			end
			ST_R_MUL: begin
				mul_a = {1'b0, divider_ohms_q};
				mul_b = {5'd0, bridge_q};
			end
			ST_T_MUL: begin
				mul_a = {{5{temp_slope_q[TEMP_W-1]}}, temp_slope_q};
				mul_b = res_q;
			end
			ST_AVG_DV: begin
				div_n = {{(DIV_N_W-ACC_W){1'b0}}, run.sum};
				div_d = DIV_D_W'(MAX_SAMPLES);
			end
			ST_MV_DIV: begin
				div_n = mul_p[DIV_N_W-1:0];
				div_d = REF_DEN;
			end
			ST_BR_DIV: begin
				div_n = {8'd0, mv_q, 16'd0};
				div_d = gain_q;
			end
			ST_R_DIV: begin
				div_n = mul_p[DIV_N_W-1:0];
				div_d = {5'd0, supply_volts_q - bridge_q};
			end
			default: ;
		endcase
	end

	assign mul_start = go_q && ((state_q == ST_MV_MUL) || (state_q == ST_G_MUL) ||
	                            (state_q == ST_R_MUL) || (state_q == ST_T_MUL));
	assign div_start = go_q && ((state_q == ST_AVG_DV) || (state_q == ST_MV_DIV) ||
	                            (state_q == ST_BR_DIV) || (state_q == ST_R_DIV));

	rsac_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	rsac_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (div_d),
		.done   (div_done),
		.q      (div_q)
	);

	// floor of product / 2^16, offsets and saturation
	always_comb begin
		shr   = mul_p[MUL_P_W-1:16];
		g_sum = {{2{shr[SHR_W-1]}}, shr} + {{(SUM_W-GAIN_W){1'b0}}, gain_offset_q};
		t_sum = {{2{shr[SHR_W-1]}}, shr} +
		        {{(SUM_W-TEMP_W){temp_offset_q[TEMP_W-1]}}, temp_offset_q};
		g_pos = !g_sum[SUM_W-1] && (g_sum != '0);
		g_sat = (g_sum[SUM_W-2:GAIN_W] != '0) ? {GAIN_W{1'b1}} : g_sum[GAIN_W-1:0];
		if (t_sum[SUM_W-1] && (t_sum[SUM_W-1:TEMP_W-1] != '1)) begin
			t_sat = {1'b1, {(TEMP_W-1){1'b0}}};
		end else if (!t_sum[SUM_W-1] && (t_sum[SUM_W-1:TEMP_W-1] != '0)) begin
			t_sat = {1'b0, {(TEMP_W-1){1'b1}}};
		end else begin
			t_sat = t_sum[TEMP_W-1:0];
		end
		q_sat19 = (div_q[DIV_N_W-1:VOLT_W] != '0) ? {VOLT_W{1'b1}} : div_q[VOLT_W-1:0];
		q_sat24 = (div_q[DIV_N_W-1:OHM_W] != '0) ? {OHM_W{1'b1}} : div_q[OHM_W-1:0];
	end

	assign out_load = (state_q == ST_HOLD) && (!out_valid_q || out_ready);

	// conversion sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q    <= 1'b0;
			fault_q <= FAULT_OK;
		end else begin
			go_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (run.valid) begin
						state_q <= ST_AVG_DV;
						go_q    <= 1'b1;
					end
				end
				ST_AVG_DV: begin
					if (div_done) begin
						state_q <= ST_MV_MUL;
						go_q    <= 1'b1;
					end
				end
				ST_MV_MUL: begin
					if (mul_done) begin
						state_q <= ST_MV_DIV;
						go_q    <= 1'b1;
					end
				end
				ST_MV_DIV: begin
					if (div_done) begin
						state_q <= ST_G_MUL;
						go_q    <= 1'b1;
					end
				end
				ST_G_MUL: begin
					if (mul_done) begin
						if (g_pos) begin
							state_q <= ST_BR_DIV;
							go_q    <= 1'b1;
						end else begin
							// gain not positive: nothing further is computed
							state_q <= ST_HOLD;
							fault_q <= FAULT_GAIN;
						end
					end
				end
				ST_BR_DIV: begin
					if (div_done) begin
						if (q_sat19 >= supply_volts_q) begin
							// bridge at or above supply, also zero supply
							state_q <= ST_HOLD;
							fault_q <= FAULT_BRIDGE;
						end else begin
							state_q <= ST_R_MUL;
							go_q    <= 1'b1;
						end
					end
				end
				ST_R_MUL: begin
					if (mul_done) begin
						state_q <= ST_R_DIV;
						go_q    <= 1'b1;
					end
				end
				ST_R_DIV: begin
					if (div_done) begin
						state_q <= ST_T_MUL;
						go_q    <= 1'b1;
					end
				end
				ST_T_MUL: begin
					if (mul_done) begin
						state_q <= ST_HOLD;
						fault_q <= FAULT_OK;
					end
				end
				ST_HOLD: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// intermediate results, zeroed where a fault cuts the chain short
	always_ff @(posedge clk) begin
		case (state_q)
			ST_AVG_DV: if (div_done) avg_q <= div_q[TRK_W-1:0];
			ST_MV_DIV: if (div_done) mv_q <= q_sat19;
			ST_G_MUL: begin
				if (mul_done) begin
					gain_q   <= g_pos ? g_sat : '0;
					bridge_q <= '0;
					res_q    <= '0;
					temp_q   <= '0;
				end
			end
			ST_BR_DIV: if (div_done) bridge_q <= q_sat19;
			ST_R_DIV:  if (div_done) res_q <= q_sat24;
			ST_T_MUL:  if (mul_done) temp_q <= t_sat;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_avg_q    <= avg_q;
			out_mv_q     <= mv_q;
			out_gain_q   <= gain_q;
			out_bridge_q <= bridge_q;
			out_res_q    <= res_q;
			out_temp_q   <= temp_q;
			out_fault_q  <= fault_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign average        = out_avg_q;
	assign measured_volts = out_mv_q;
	assign gain           = out_gain_q;
	assign bridge_volts   = out_bridge_q;
	assign resistance     = out_res_q;
	assign temperature    = out_temp_q;
	assign fault          = out_fault_q;

endmodule

`default_nettype wire
